>>> src/mwc_pkg.sv
// Shared constants and controller/datapath interface types for the
// lag-4691 multiply-with-carry generator. No dependencies.
package mwc_pkg;

  localparam int unsigned LAG     = 4691;
  localparam int unsigned IDX_W   = $clog2(LAG);
  localparam int unsigned CNT_W   = $clog2(LAG + 1);
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned CARRY_W = 14;

  localparam logic [DATA_W-1:0] CNG_MUL = 32'd69069;
  localparam logic [DATA_W-1:0] CNG_ADD = 32'd123;

  localparam int unsigned MWC_SHIFT = 13;
  localparam int unsigned HI_SHIFT  = 19;

  localparam int unsigned XS_A = 13;
  localparam int unsigned XS_B = 17;
  localparam int unsigned XS_C = 5;

  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_SEED = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic seed_load;   // latch seeds, clear fill counter
    logic fill;        // one fill step
    logic draw_read;   // advance position, read table word
    logic draw_write;  // update word and carry, load result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic fill_done;   // this fill step writes the last entry
  } sts_t;

endpackage

>>> src/mwc_lag4691_generator_top.sv
// Top level of the lag-4691 multiply-with-carry generator: stream ports,
// controller and datapath. Depends on mwc_pkg, mwc_ctrl and mwc_datapath.
//
// A draw word (tuser = 0): the accept cycle advances the position and reads
// the table; the write state then forms the new word and carry, writes the
// word back through the single table write port and loads the output
// register; the next word is taken once the controller is idle again. A seed
// word (tuser = 1) walks the 4691-entry table one entry a cycle and holds
// tready low after the accept cycle until the last entry is written; it returns
// no word. The table must be seeded before the first draw. A waiting result
// does not block seeding, and a draw waits in its write cycle only while the
// previous result has not been taken.
module mwc_lag4691_generator_top import mwc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // [31:0] cng_seed, [63:32] xorshift_seed
  input  logic        s_axis_tuser,  // [0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // [31:0] random_word
);

  cmd_t cmd;
  sts_t sts;

  mwc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  mwc_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cng_seed_i     (s_axis_tdata[31:0]),
    .xorshift_seed_i(s_axis_tdata[63:32]),
    .random_word_o  (m_axis_tdata)
  );

endmodule

>>> src/mwc_ctrl.sv
// Sequencer for seed and draw items of the multiply-with-carry generator.
// Depends on mwc_pkg for the command and status types.
module mwc_ctrl import mwc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_op_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o,
  input  sts_t sts_i
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_FILL = 3'b010,
    ST_WR   = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_op_i == OP_SEED) begin
            cmd_o.seed_load = 1'b1;
            state_d         = ST_FILL;
          end else begin
            cmd_o.draw_read = 1'b1;
            state_d         = ST_WR;
          end
        end
      end
      ST_FILL: begin
        cmd_o.fill = 1'b1;
        if (sts_i.fill_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_WR: begin
        // hold the word until the result register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.draw_write = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.draw_write) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_write_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.draw_write |=> out_valid_q)
    else $error("result valid not set after draw write");

  a_valid_rise_from_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_WR))
    else $error("result valid rose outside draw write");

  a_fill_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FILL && sts_i.fill_done) |=> state_q == ST_IDLE)
    else $error("fill did not end after last entry");

endmodule

>>> src/mwc_datapath.sv
// Lag table memory, seeders, carry, position and result register.
// Depends on mwc_pkg for sizes, constants and the command/status types.
module mwc_datapath import mwc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic [DATA_W-1:0] cng_seed_i,
  input  logic [DATA_W-1:0] xorshift_seed_i,
  output logic [DATA_W-1:0] random_word_o
);

  logic [DATA_W-1:0] lag_mem [LAG];

  logic [DATA_W-1:0]  cng_q, cng_d;
  logic [DATA_W-1:0]  xs_q, xs_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   cnt_m1;
  logic [IDX_W-1:0]   pos_q, pos_d, pos_next;
  logic [CARRY_W-1:0] carry_q, carry_d;
  logic [DATA_W-1:0]  rd_q;
  logic [DATA_W-1:0]  res_q;
  logic [DATA_W-1:0]  mwc_t;
  logic               fill_last;
  logic               we;
  logic [IDX_W-1:0]   wa;
  logic [DATA_W-1:0]  wd;

  function automatic logic [DATA_W-1:0] xs_step(input logic [DATA_W-1:0] v);
    logic [DATA_W-1:0] r;
    r = v ^ (v << XS_A);
    r = r ^ (r >> XS_B);
    r = r ^ (r << XS_C);
    return r;
  endfunction

  assign fill_last      = (cnt_q == CNT_W'(LAG));
  assign sts_o.fill_done = fill_last;
  assign cnt_m1         = cnt_q - CNT_W'(1);
  assign pos_next       = (pos_q == IDX_W'(LAG - 1)) ? '0 : pos_q + IDX_W'(1);

  // x * 8193 plus carry
  assign mwc_t = (rd_q << MWC_SHIFT) + rd_q + DATA_W'(carry_q);

  always_comb begin
    cng_d   = cng_q;
    xs_d    = xs_q;
    cnt_d   = cnt_q;
    pos_d   = pos_q;
    carry_d = carry_q;
    if (cmd_i.seed_load) begin
      cng_d = cng_seed_i;
      xs_d  = xorshift_seed_i;
      cnt_d = '0;
    end
    if (cmd_i.fill) begin
      cnt_d = cnt_q + CNT_W'(1);
      if (fill_last) begin
        pos_d   = IDX_W'(LAG - 1);
        carry_d = '0;
      end else begin
        cng_d = cng_q * CNG_MUL + CNG_ADD;
        xs_d  = xs_step(xs_q);
      end
    end
    if (cmd_i.draw_read) begin
      pos_d = pos_next;
    end
    if (cmd_i.draw_write) begin
      carry_d = CARRY_W'(mwc_t < rd_q) + CARRY_W'(rd_q >> HI_SHIFT);
    end
  end

  // fill writes lag one step behind the seeders
  always_comb begin
    we = (cmd_i.fill && (cnt_q != '0)) || cmd_i.draw_write;
    wa = cmd_i.fill ? cnt_m1[IDX_W-1:0] : pos_q;
    wd = cmd_i.fill ? (cng_q + xs_q) : mwc_t;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      lag_mem[wa] <= wd;
    end
    if (cmd_i.draw_read) begin
      rd_q <= lag_mem[pos_next];
    end
  end

  always_ff @(posedge clk_i) begin
    cng_q <= cng_d;
    xs_q  <= xs_d;
    if (cmd_i.draw_write) begin
      res_q <= mwc_t;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      pos_q   <= IDX_W'(LAG - 1);
      carry_q <= '0;
    end else begin
      cnt_q   <= cnt_d;
      pos_q   <= pos_d;
      carry_q <= carry_d;
    end
  end

  assign random_word_o = res_q;

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= IDX_W'(LAG - 1))
    else $error("position out of table range");

  a_seed_end_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.fill && fill_last) |=> (pos_q == IDX_W'(LAG - 1)) && (carry_q == '0))
    else $error("seed did not reset position and carry");

  a_port_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.fill && (cmd_i.draw_read || cmd_i.draw_write)))
    else $error("fill overlaps a draw access");

endmodule
